[rtl/dts_pkg.sv]
// Shared types and constants for the dual encoder turn solver.
`timescale 1ns / 1ps
`default_nettype none
package dts_pkg;

  localparam int TURN_W   = 24;
  localparam int ANGLE_W  = 16;
  localparam int WEIGHT_W = 16;
  localparam int TEETH_W  = 7;
  localparam int CFG_W    = 24;
  localparam int CFG_IDX_W = 3;
  localparam int SCORE_W  = 32;
  localparam int PERIOD_W = TEETH_W + TURN_W;
  localparam int DIVISOR_W = 32;

  localparam logic [SCORE_W-1:0]  SCORE_NONE = '1;
  localparam logic [SCORE_W-1:0]  SCORE_CAP  = 32'hFFFF_FFFE;
  localparam logic [TURN_W-1:0]   TURN_ALL   = '1;
  localparam logic [WEIGHT_W:0]   UNIT_WEIGHT = 17'd256;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_TEETH_A    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TEETH_B    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RATIO_A    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RATIO_B    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BLEND_A    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BLEND_B    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_LIMIT = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_PROX_W     = 3'd7;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic est;
    logic wmul;
    logic start_mean;
    logic take_mean;
    logic chk;
    logic start_mod;
    logic take_mod;
    logic pen;
    logic upd;
    logic step;
    logic publish;
  } dts_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic empty;
    logic div_done;
    logic over;
    logic need_mod;
    logic last_pair;
  } dts_stat_t;

endpackage
`default_nettype wire

[rtl/dual_encoder_turn_solver.sv]
// Top level of the dual encoder turn solver.
// Usage: write the eight configuration registers through cfg_we, cfg_index
// and cfg_data while no request is in flight. Each input request carries two
// encoder angles and an optional previous turn; each one yields exactly one
// result request with the chosen turn and a found flag.
// A request is taken when in_valid is high and in_stall is low; in_stall is
// high for the whole search of one request. The search visits every pair of
// revolution counts, B outer and A inner. Per pair, the shared restoring
// divider of W = clog2(MAX_TEETH) + 41 bits (47 at MAX_TEETH = 64) forms
// the weighted mean and, when the proximity term wraps, also the wrap
// remainder.
// The result sits in an output register; while out_stall holds it, the next
// request is still taken and searched, and it waits only to publish.
// Reset (rst_n low, synchronous) restores the register defaults, empties the
// output register and returns the controller to idle.
`timescale 1ns / 1ps
`default_nettype none
module dual_encoder_turn_solver #(
  parameter int MAX_TEETH = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [dts_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [dts_pkg::CFG_W-1:0]           cfg_data,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [dts_pkg::ANGLE_W-1:0]         in_angle_a,
  input  wire logic [dts_pkg::ANGLE_W-1:0]         in_angle_b,
  input  wire logic [dts_pkg::TURN_W-1:0]          in_previous_turn,
  input  wire logic                                in_previous_valid,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [dts_pkg::TURN_W-1:0]               out_turn,
  output logic                                     out_found
);
  import dts_pkg::*;

  dts_cmd_t  cmd;
  dts_stat_t stat;

  dts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  dts_dp #(.MAX_TEETH(MAX_TEETH)) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_angle_a        (in_angle_a),
    .in_angle_b        (in_angle_b),
    .in_previous_turn  (in_previous_turn),
    .in_previous_valid (in_previous_valid),
    .cmd               (cmd),
    .stat              (stat),
    .out_turn          (out_turn),
    .out_found         (out_found)
  );

endmodule
`default_nettype wire

[rtl/dts_div.sv]
// Restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module dts_div #(
  parameter int DVD_W = 47
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  input  wire logic [DVD_W-1:0]                  dividend,
  input  wire logic [dts_pkg::DIVISOR_W-1:0]     divisor,
  output logic                                   done,
  output logic [DVD_W-1:0]                       quotient,
  output logic [dts_pkg::DIVISOR_W-1:0]          remainder
);
  import dts_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0]     quo_r, quo_nxt;
  logic [DIVISOR_W-1:0] rem_r, rem_nxt, dvs_r;
  logic [CNT_W-1:0]     cnt_r;
  logic                 busy_r, done_r;
  logic [DIVISOR_W:0]   shifted;
  logic                 fits;

  // One shift and trial subtract
  always_comb begin
    shifted = {rem_r, quo_r[DVD_W-1]};
    fits    = shifted >= {1'b0, dvs_r};
    rem_nxt = fits ? DIVISOR_W'(shifted - {1'b0, dvs_r}) : shifted[DIVISOR_W-1:0];
    quo_nxt = {quo_r[DVD_W-2:0], fits};
  end

  // Control of the iteration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Quotient and remainder
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule
`default_nettype wire

[rtl/dts_dp.sv]
// Datapath: configuration, pair counters, estimates, score and best result.
`timescale 1ns / 1ps
`default_nettype none
module dts_dp #(
  parameter int MAX_TEETH = 64
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_we,
  input  wire logic [dts_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [dts_pkg::CFG_W-1:0]           cfg_data,
  input  wire logic [dts_pkg::ANGLE_W-1:0]         in_angle_a,
  input  wire logic [dts_pkg::ANGLE_W-1:0]         in_angle_b,
  input  wire logic [dts_pkg::TURN_W-1:0]          in_previous_turn,
  input  wire logic                                in_previous_valid,
  input  wire dts_pkg::dts_cmd_t                   cmd,
  output dts_pkg::dts_stat_t                       stat,
  output logic [dts_pkg::TURN_W-1:0]               out_turn,
  output logic                                     out_found
);
  import dts_pkg::*;

  localparam int CW  = $clog2(MAX_TEETH);
  localparam int NW  = $clog2(MAX_TEETH + 1);
  localparam int PW  = CW + ANGLE_W;
  localparam int EW  = CW + TURN_W;
  localparam int SW  = EW + WEIGHT_W + 1;
  localparam int PNW = PERIOD_W + WEIGHT_W;

  // Configuration registers
  logic [TEETH_W-1:0]  teeth_a_r, teeth_b_r;
  logic [TURN_W-1:0]   ratio_a_r, ratio_b_r, turn_limit_r;
  logic [WEIGHT_W-1:0] blend_a_r, blend_b_r, prox_w_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      teeth_a_r    <= TEETH_W'(1);
      teeth_b_r    <= TEETH_W'(1);
      ratio_a_r    <= TURN_W'(65536);
      ratio_b_r    <= TURN_W'(65536);
      blend_a_r    <= WEIGHT_W'(256);
      blend_b_r    <= WEIGHT_W'(256);
      turn_limit_r <= TURN_ALL;
      prox_w_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_TEETH_A:    teeth_a_r    <= cfg_data[TEETH_W-1:0];
        REG_TEETH_B:    teeth_b_r    <= cfg_data[TEETH_W-1:0];
        REG_RATIO_A:    ratio_a_r    <= cfg_data[TURN_W-1:0];
        REG_RATIO_B:    ratio_b_r    <= cfg_data[TURN_W-1:0];
        REG_BLEND_A:    blend_a_r    <= cfg_data[WEIGHT_W-1:0];
        REG_BLEND_B:    blend_b_r    <= cfg_data[WEIGHT_W-1:0];
        REG_TURN_LIMIT: turn_limit_r <= cfg_data[TURN_W-1:0];
        REG_PROX_W:     prox_w_r     <= cfg_data[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Per-request values latched at load
  logic [ANGLE_W-1:0]  angle_a_r, angle_b_r;
  logic [TURN_W-1:0]   prev_r;
  logic                use_prev_r;
  logic [WEIGHT_W:0]   tot_r;
  logic [PERIOD_W-1:0] period_r;
  logic [NW-1:0]       na_r, nb_r;
  logic [CW-1:0]       cnt_a_r, cnt_b_r;

  logic [WEIGHT_W:0]   tot_raw;
  logic [NW-1:0]       nb_lim, na_lim;

  always_comb begin
    tot_raw = {1'b0, blend_a_r} + {1'b0, blend_b_r};
    nb_lim  = (int'(teeth_a_r) > MAX_TEETH) ? NW'(MAX_TEETH) : NW'(teeth_a_r);
    na_lim  = (int'(teeth_b_r) > MAX_TEETH) ? NW'(MAX_TEETH) : NW'(teeth_b_r);
  end

  // Estimates, weighted terms and gap
  logic [EW-1:0]          ea_r, eb_r, diff_r;
  logic [EW+WEIGHT_W-1:0] wa_r, wb_r;
  logic [PW+TURN_W-1:0]   pa_prod, pb_prod;
  logic [SW-1:0]          mean_r;
  logic [PERIOD_W-1:0]    d_r;
  logic [PNW-1:0]         pen_r;
  logic [TURN_W-1:0]      best_turn_r;
  logic [SCORE_W-1:0]     best_score_r;
  logic [TURN_W-1:0]      out_turn_r;
  logic                   out_found_r;

  assign pa_prod = PW'({cnt_a_r, angle_a_r}) * (PW+TURN_W)'(ratio_a_r);
  assign pb_prod = PW'({cnt_b_r, angle_b_r}) * (PW+TURN_W)'(ratio_b_r);

  // Shared divider: mean first, then the wrap remainder
  logic                 div_start, div_done;
  logic [SW-1:0]        div_dvd, div_quo;
  logic [DIVISOR_W-1:0] div_dvs, div_rem;
  logic [TURN_W-1:0]    d0;
  logic [PERIOD_W-1:0]  rem_p, rem_c, rem_w;
  logic [47:0]          score_w;
  logic [SCORE_W-1:0]   score_s;

  always_comb begin
    d0 = (mean_r[TURN_W-1:0] > prev_r) ? mean_r[TURN_W-1:0] - prev_r
                                         : prev_r - mean_r[TURN_W-1:0];
    div_start = cmd.start_mean | cmd.start_mod;
    if (cmd.start_mean) begin
      div_dvd = SW'(wa_r) + SW'(wb_r);
      div_dvs = DIVISOR_W'(tot_r);
    end else begin
      div_dvd = SW'(d0);
      div_dvs = DIVISOR_W'(period_r);
    end
    rem_p = div_rem[PERIOD_W-1:0];
    rem_c = period_r - rem_p;
    rem_w = (rem_c < rem_p) ? rem_c : rem_p;
    score_w = 48'(diff_r) + 48'(pen_r[PNW-1:8]);
    score_s = (score_w > 48'(SCORE_CAP)) ? SCORE_CAP : score_w[SCORE_W-1:0];
  end

  dts_div #(.DVD_W(SW)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Work registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      angle_a_r  <= in_angle_a;
      angle_b_r  <= in_angle_b;
      prev_r     <= in_previous_turn;
      use_prev_r <= in_previous_valid & (prox_w_r != '0);
      tot_r      <= (tot_raw == '0) ? UNIT_WEIGHT : tot_raw;
      if (turn_limit_r != '0 && turn_limit_r != TURN_ALL) begin
        period_r <= PERIOD_W'(turn_limit_r);
      end else begin
        period_r <= PERIOD_W'(teeth_a_r) * PERIOD_W'(ratio_b_r);
      end
      na_r         <= na_lim;
      nb_r         <= nb_lim;
      cnt_a_r      <= '0;
      cnt_b_r      <= '0;
      best_turn_r  <= '0;
      best_score_r <= SCORE_NONE;
    end
    if (cmd.est) begin
      ea_r <= pa_prod[PW+TURN_W-1:16];
      eb_r <= pb_prod[PW+TURN_W-1:16];
    end
    if (cmd.wmul) begin
      wa_r   <= ea_r * (EW+WEIGHT_W)'(blend_a_r);
      wb_r   <= eb_r * (EW+WEIGHT_W)'(blend_b_r);
      diff_r <= (ea_r > eb_r) ? ea_r - eb_r : eb_r - ea_r;
    end
    if (cmd.take_mean) begin
      mean_r <= div_quo;
    end
    if (cmd.chk) begin
      d_r <= PERIOD_W'(d0);
    end
    if (cmd.take_mod) begin
      d_r <= rem_w;
    end
    if (cmd.pen) begin
      pen_r <= use_prev_r ? PNW'(d_r) * PNW'(prox_w_r) : '0;
    end
    if (cmd.upd && score_s < best_score_r) begin
      best_score_r <= score_s;
      best_turn_r  <= mean_r[TURN_W-1:0];
    end
    // Advance the pair: A count inner, B count outer
    if (cmd.step) begin
      if (stat.last_pair || (NW'(cnt_a_r) + NW'(1)) == na_r) begin
        cnt_a_r <= '0;
        cnt_b_r <= cnt_b_r + CW'(1);
      end else begin
        cnt_a_r <= cnt_a_r + CW'(1);
      end
    end
    if (cmd.publish) begin
      out_turn_r  <= best_turn_r;
      out_found_r <= best_score_r != SCORE_NONE;
    end
  end

  // Status to the controller
  always_comb begin
    stat.empty     = (na_r == '0) || (nb_r == '0);
    stat.div_done  = div_done;
    stat.over      = mean_r > SW'(turn_limit_r);
    stat.need_mod  = use_prev_r && (period_r != '0);
    stat.last_pair = ((NW'(cnt_a_r) + NW'(1)) == na_r) &&
                     ((NW'(cnt_b_r) + NW'(1)) == nb_r);
  end

  assign out_turn  = out_turn_r;
  assign out_found = out_found_r;

endmodule
`default_nettype wire

[rtl/dts_ctrl.sv]
// Controller: sequences the pair search and the request handshakes.
`timescale 1ns / 1ps
`default_nettype none
module dts_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  output logic                    out_valid,
  input  wire logic               out_stall,
  input  wire dts_pkg::dts_stat_t stat,
  output dts_pkg::dts_cmd_t       cmd
);
  import dts_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_EST, S_WMUL, S_SUM, S_MEAN, S_CHK, S_MOD, S_PEN, S_UPD, S_NEXT, S_DONE
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EST;
        end
      end
      S_EST: begin
        if (stat.empty) begin
          state_nxt = S_DONE;
        end else begin
          cmd.est   = 1'b1;
          state_nxt = S_WMUL;
        end
      end
      S_WMUL: begin
        cmd.wmul  = 1'b1;
        state_nxt = S_SUM;
      end
      S_SUM: begin
        cmd.start_mean = 1'b1;
        state_nxt      = S_MEAN;
      end
      S_MEAN: begin
        if (stat.div_done) begin
          cmd.take_mean = 1'b1;
          state_nxt     = S_CHK;
        end
      end
      S_CHK: begin
        cmd.chk = 1'b1;
        if (stat.over) begin
          state_nxt = S_NEXT;
        end else if (stat.need_mod) begin
          cmd.start_mod = 1'b1;
          state_nxt     = S_MOD;
        end else begin
          state_nxt = S_PEN;
        end
      end
      S_MOD: begin
        if (stat.div_done) begin
          cmd.take_mod = 1'b1;
          state_nxt    = S_PEN;
        end
      end
      S_PEN: begin
        cmd.pen   = 1'b1;
        state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.upd   = 1'b1;
        state_nxt = S_NEXT;
      end
      S_NEXT: begin
        cmd.step  = 1'b1;
        state_nxt = stat.last_pair ? S_DONE : S_EST;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          cmd.publish = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold the result valid until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.publish) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

[sim/dual_encoder_turn_solver_test.sv]
// Testbench for the dual encoder turn solver: directed and random requests
// checked against a behavioral turn search.
`timescale 1ns / 1ps
module dual_encoder_turn_solver_test;
  import dts_pkg::*;

  typedef struct {
    logic [TURN_W-1:0] turn;
    logic              found;
  } turn_result_t;

  // Track register values, predict each turn and hold the pending results
  class turn_scoreboard;
    logic [TEETH_W-1:0]  teeth_a = 7'd1, teeth_b = 7'd1;
    logic [TURN_W-1:0]   ratio_a = 24'h010000, ratio_b = 24'h010000;
    logic [WEIGHT_W-1:0] blend_a = 16'd256, blend_b = 16'd256;
    logic [TURN_W-1:0]   turn_limit = TURN_ALL;
    logic [WEIGHT_W-1:0] prox_weight = 16'd0;
    turn_result_t        pending_turns[$];
    int                  errors = 0;

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_TEETH_A:    teeth_a = data[TEETH_W-1:0];
        REG_TEETH_B:    teeth_b = data[TEETH_W-1:0];
        REG_RATIO_A:    ratio_a = data;
        REG_RATIO_B:    ratio_b = data;
        REG_BLEND_A:    blend_a = data[WEIGHT_W-1:0];
        REG_BLEND_B:    blend_b = data[WEIGHT_W-1:0];
        REG_TURN_LIMIT: turn_limit = data;
        REG_PROX_W:     prox_weight = data[WEIGHT_W-1:0];
        default: ;
      endcase
    endfunction

    // Estimate of the turret turn from one encoder at revolution count n
    function longint unsigned gear_estimate(int n, logic [ANGLE_W-1:0] ang,
                                            logic [TURN_W-1:0] ratio);
      longint unsigned pos;
      pos = (longint'(n) << 16) + ang;
      return (pos * ratio) >> 16;
    endfunction

    function void note_request(logic [ANGLE_W-1:0] ang_a, logic [ANGLE_W-1:0] ang_b,
                               logic [TURN_W-1:0] prev, logic prev_ok);
      longint unsigned tot, period, ea, eb, mean, score, d, best_score;
      logic [TURN_W-1:0] best_turn;
      int tries_b, tries_a;
      bit use_prev;
      turn_result_t r;
      use_prev = prev_ok && (prox_weight != 0);
      tot = longint'(blend_a) + blend_b;
      if (tot == 0) tot = 256;
      if (turn_limit != 0 && turn_limit != TURN_ALL) period = turn_limit;
      else period = longint'(teeth_a) * ratio_b;
      tries_b = (teeth_a > 64) ? 64 : teeth_a;
      tries_a = (teeth_b > 64) ? 64 : teeth_b;
      best_turn = '0;
      best_score = 64'hFFFF_FFFF;
      // Scan B counts outer, A counts inner; first strictly lowest score wins
      for (int i = 0; i < tries_b; i++) begin
        eb = gear_estimate(i, ang_b, ratio_b);
        for (int j = 0; j < tries_a; j++) begin
          ea = gear_estimate(j, ang_a, ratio_a);
          mean = (ea * blend_a + eb * blend_b) / tot;
          if (mean > turn_limit) continue;
          score = (ea > eb) ? ea - eb : eb - ea;
          if (use_prev) begin
            d = (mean > prev) ? mean - prev : prev - mean;
            if (period != 0) begin
              d = d % period;
              if (period - d < d) d = period - d;
            end
            score += (d * prox_weight) >> 8;
          end
          if (score > 64'hFFFF_FFFE) score = 64'hFFFF_FFFE;
          if (score < best_score) begin
            best_score = score;
            best_turn = mean[TURN_W-1:0];
          end
        end
      end
      r.found = (best_score != 64'hFFFF_FFFF);
      r.turn = r.found ? best_turn : '0;
      pending_turns.push_back(r);
    endfunction

    function void check_result(logic [TURN_W-1:0] turn, logic found);
      turn_result_t e;
      if (pending_turns.size() == 0) begin
        $display("%0t: unexpected result turn=%h found=%b", $time, turn, found);
        errors++;
        return;
      end
      e = pending_turns.pop_front();
      if (turn !== e.turn) begin
        $display("%0t: turn expected %h actual %h", $time, e.turn, turn);
        errors++;
      end
      if (found !== e.found) begin
        $display("%0t: found expected %b actual %b", $time, e.found, found);
        errors++;
      end
    endfunction
  endclass

  localparam int IDLE_LIMIT = 2000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_TEETH_A;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [ANGLE_W-1:0] in_angle_a = '0, in_angle_b = '0;
  logic [TURN_W-1:0] in_previous_turn = '0;
  logic in_previous_valid = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [TURN_W-1:0] out_turn;
  logic out_found;

  turn_scoreboard sb = new();
  int burst_left = 0;
  int stall_run = 0;
  bit stall_quiet = 1'b0;
  int idle_cycles = 0;

  always #5 clk = ~clk;

  dual_encoder_turn_solver uut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_angle_a(in_angle_a), .in_angle_b(in_angle_b),
    .in_previous_turn(in_previous_turn), .in_previous_valid(in_previous_valid),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_turn(out_turn), .out_found(out_found)
  );

  // Check every result taken by the receiver
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_turn, out_found);
  end

  // Stall the result channel in runs of random length
  always @(negedge clk) begin
    if (stall_run == 0) begin
      out_stall <= stall_quiet ? 1'b0 : ($urandom_range(0, 2) == 0);
      stall_run = $urandom_range(1, 12);
    end
    stall_run--;
  end

  // Abort when nothing moves for too long
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.set_reg(idx, data);
  endtask

  task automatic load_setup(input int ta, input int tb, input logic [23:0] ra,
                            input logic [23:0] rb, input logic [15:0] wa,
                            input logic [15:0] wb, input logic [23:0] mt,
                            input logic [15:0] pw);
    write_reg(REG_TEETH_A, CFG_W'(ta));
    write_reg(REG_TEETH_B, CFG_W'(tb));
    write_reg(REG_RATIO_A, ra);
    write_reg(REG_RATIO_B, rb);
    write_reg(REG_BLEND_A, CFG_W'(wa));
    write_reg(REG_BLEND_B, CFG_W'(wb));
    write_reg(REG_TURN_LIMIT, mt);
    write_reg(REG_PROX_W, CFG_W'(pw));
  endtask

  // Send one request; the sender works in bursts with random gaps
  task automatic push_request(input logic [15:0] aa, input logic [15:0] ab,
                              input logic [23:0] pt, input logic pv);
    if (burst_left == 0) begin
      repeat ($urandom_range(0, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 8);
    end
    in_valid = 1'b1;
    in_angle_a = aa;
    in_angle_b = ab;
    in_previous_turn = pt;
    in_previous_valid = pv;
    do @(posedge clk); while (in_stall);
    sb.note_request(aa, ab, pt, pv);
    burst_left--;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic drain;
    while (sb.pending_turns.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
  endtask

  function automatic logic [23:0] pick24();
    case ($urandom_range(0, 4))
      0: return 24'h000000;
      1: return 24'hFFFFFF;
      2: return 24'($urandom);
      default: return 24'($urandom_range(24'h008000, 24'h040000));
    endcase
  endfunction

  function automatic logic [15:0] pick16();
    case ($urandom_range(0, 4))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'($urandom);
      default: return 16'($urandom_range(16'h0040, 16'h0400));
    endcase
  endfunction

  // Random requests: most are consistent readings of a true turn
  task automatic random_requests(input int n);
    logic [23:0] t;
    logic [47:0] pa, pb;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 3) != 0) begin
        t = 24'($urandom_range(0, 24'h060000));
        pa = t * sb.ratio_a;
        pb = t * sb.ratio_b;
        push_request(pa[31:16], pb[31:16],
                     t + 24'($urandom_range(0, 24'h004000)) - 24'h002000,
                     1'($urandom_range(0, 1)));
      end else begin
        push_request(16'($urandom), 16'($urandom), 24'($urandom),
                     1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Reset registers: one pair only
    stall_quiet = 1'b1;
    push_request(16'h0000, 16'h0000, 24'h000000, 1'b0);
    push_request(16'hFFFF, 16'hFFFF, 24'hFFFFFF, 1'b1);
    push_request(16'h8000, 16'h4000, 24'h000000, 1'b1);
    drain();

    // Limited turn with proximity wrap
    stall_quiet = 1'b0;
    load_setup(3, 4, 24'h018000, 24'h010000, 16'h0100, 16'h0200, 24'h030000, 16'h0100);
    push_request(16'h0000, 16'hFFFF, 24'h000000, 1'b1);
    push_request(16'hFFFF, 16'h0000, 24'hFFFFFF, 1'b1);
    push_request(16'h1234, 16'h9ABC, 24'h012345, 1'b0);
    push_request(16'hC000, 16'h2000, 24'h020000, 1'b1);
    drain();

    // Zero weight sum, period from teeth, saturated proximity
    load_setup(5, 3, 24'hFFFFFF, 24'h020000, 16'h0000, 16'h0000, 24'h000000, 16'hFFFF);
    push_request(16'h5555, 16'hAAAA, 24'h00FFFF, 1'b1);
    push_request(16'hFFFF, 16'h0001, 24'hFFFFFF, 1'b1);
    push_request(16'h0000, 16'h0000, 24'h800000, 1'b0);
    drain();

    // Zero ratio gives a zero period; unlimited max turn
    load_setup(4, 2, 24'h000000, 24'h000000, 16'hFFFF, 16'h0001, 24'hFFFFFF, 16'h0080);
    push_request(16'h7FFF, 16'h8000, 24'h000100, 1'b1);
    push_request(16'hFFFF, 16'hFFFF, 24'hFFFFFF, 1'b1);
    drain();

    // No counts to try: nothing found
    load_setup(0, 5, 24'h010000, 24'h010000, 16'h0100, 16'h0100, 24'hFFFFFF, 16'h0000);
    push_request(16'h4000, 16'h4000, 24'h000000, 1'b0);
    drain();
    write_reg(REG_TEETH_A, CFG_W'(3));
    write_reg(REG_TEETH_B, CFG_W'(0));
    push_request(16'h4000, 16'h4000, 24'h000000, 1'b1);
    drain();

    // Teeth above the limit clamp to the maximum
    load_setup(127, 1, 24'h008000, 24'h030000, 16'h0100, 16'h0300, 24'h7FFFFF, 16'h0200);
    push_request(16'h1111, 16'hEEEE, 24'h123456, 1'b1);
    push_request(16'hFFFF, 16'h0000, 24'h000000, 1'b0);
    drain();

    // Full search over the largest count grid
    load_setup(64, 64, 24'h00C000, 24'h014000, 16'h0180, 16'h0080, 24'h200000, 16'h0040);
    push_request(16'h3C3C, 16'hC3C3, 24'h100000, 1'b1);
    drain();

    // Random register settings with small count grids
    for (int ph = 0; ph < 10; ph++) begin
      stall_quiet = (ph % 3 == 0);
      load_setup($urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 5),
                 $urandom_range(1, 5), pick24(), pick24(), pick16(), pick16(),
                 pick24(), pick16());
      random_requests(12);
      drain();
    end

    if (sb.errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
